// ----- design/dram_zq_calibration_scheduler_core_assert.svh -----
// ----------------------------------------------------------------------------
// ZQ calibration scheduler assertion macros
// Concurrent check helpers clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef DRAM_ZQ_CALIBRATION_SCHEDULER_CORE_ASSERT_SVH
`define DRAM_ZQ_CALIBRATION_SCHEDULER_CORE_ASSERT_SVH

// same-cycle implication
`define DZCS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DZCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/dzcs_pkg.sv -----
// ----------------------------------------------------------------------------
// ZQ calibration scheduler package
// Shared types, register indexes and event codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dzcs_pkg;

  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd100;

  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_MS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TWO_RANKS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANK0_ABSENT = 2'd2;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2
  } op_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] period_ms;
    logic                two_ranks;
    logic                rank0_absent;
  } cfg_t;

  typedef struct packed {
    logic               fire;
    op_t                op;
    logic [STAMP_W-1:0] stamp;
  } step_req_t;

  typedef struct packed {
    logic                cal_issued;
    logic                cal_long;
    logic                cal_rank;
    logic [PERIOD_W-1:0] next_delay_ticks;
    logic [STAMP_W-1:0]  interval_min;
    logic [STAMP_W-1:0]  interval_max;
    logic [STAMP_W-1:0]  last_expiry_tick;
  } out_word_t;

endpackage

// ----- design/dzcs_if.sv -----
// ----------------------------------------------------------------------------
// ZQ calibration scheduler channels
// Valid/ready channels for event words and result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dzcs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] cycle_stamp;

  modport source (output valid, output op, output cycle_stamp, input ready);
  modport sink (input valid, input op, input cycle_stamp, output ready);
endinterface

interface dzcs_out_if;
  logic        valid;
  logic        ready;
  logic        cal_issued;
  logic        cal_long;
  logic        cal_rank;
  logic [15:0] next_delay_ticks;
  logic [31:0] interval_min;
  logic [31:0] interval_max;
  logic [31:0] last_expiry_tick;

  modport source (output valid, output cal_issued, output cal_long, output cal_rank,
                  output next_delay_ticks, output interval_min, output interval_max,
                  output last_expiry_tick, input ready);
  modport sink (input valid, input cal_issued, input cal_long, input cal_rank,
                input next_delay_ticks, input interval_min, input interval_max,
                input last_expiry_tick, output ready);
endinterface

// ----- design/dzcs_reload.sv -----
// ----------------------------------------------------------------------------
// ZQ calibration reload calculator
// Computes max(1, ceil((period >> two_ranks) / MS_PER_TICK)) by reciprocal
// multiplication, exact for every 17-bit dividend.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dzcs_reload #(
  parameter int unsigned MS_PER_TICK = 10
) (
  input  logic [15:0] period_ms,
  input  logic        two_ranks,
  output logic [15:0] reload
);

  localparam int unsigned X_W      = 17;
  localparam int unsigned LOG_M    = $clog2(MS_PER_TICK);
  localparam int unsigned SHIFT    = X_W + LOG_M;
  localparam int unsigned RECIP_W  = SHIFT + 1;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << SHIFT) + MS_PER_TICK - 1) / MS_PER_TICK;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
  localparam logic [X_W-1:0] BIAS = X_W'(MS_PER_TICK - 1);

  logic [15:0]             half;
  logic [X_W-1:0]          dividend;
  logic [X_W+RECIP_W-1:0]  product;
  logic [X_W-1:0]          quot;

  always_comb begin
    half     = two_ranks ? {1'b0, period_ms[15:1]} : period_ms;
    dividend = {1'b0, half} + BIAS;
    product  = (X_W+RECIP_W)'(dividend) * (X_W+RECIP_W)'(RECIP);
    quot     = product[SHIFT +: X_W];
    if (quot == '0) begin
      reload = 16'd1;
    end else if (quot[X_W-1]) begin
      reload = 16'hFFFF;
    end else begin
      reload = quot[15:0];
    end
  end

endmodule

// ----- design/dzcs_sched.sv -----
// ----------------------------------------------------------------------------
// ZQ calibration scheduler state
// Holds countdown, rank rotation and interval statistics; applies one event
// word per fire and forms its result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dzcs_sched #(
  parameter int unsigned RANKS = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dzcs_pkg::cfg_t      cfg,
  input  logic [15:0]         reload,
  input  dzcs_pkg::step_req_t req,
  output dzcs_pkg::out_word_t result
);

  localparam int unsigned SLOT_W = (RANKS > 1) ? $clog2(RANKS) : 1;

  logic              running_r, running_nxt;
  logic [15:0]       countdown_r, countdown_nxt;
  logic              rank_ptr_r, rank_ptr_nxt;
  logic [RANKS-1:0]  need_long_r, need_long_nxt;
  logic [RANKS-1:0]  first_r, first_nxt;
  logic [31:0]       prev_stamp_r [RANKS];
  logic [31:0]       min_r, min_nxt;
  logic [31:0]       max_r, max_nxt;
  logic [31:0]       tick_cnt_r, tick_cnt_nxt;
  logic [31:0]       expiry_r, expiry_nxt;

  logic [SLOT_W-1:0] slot;
  logic              expire;
  logic [31:0]       dt;

  always_comb begin
    slot = (RANKS > 1) ? SLOT_W'(rank_ptr_r) : '0;
    dt   = req.stamp - prev_stamp_r[slot];

    running_nxt   = running_r;
    countdown_nxt = countdown_r;
    rank_ptr_nxt  = rank_ptr_r;
    need_long_nxt = need_long_r;
    first_nxt     = first_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    tick_cnt_nxt  = tick_cnt_r;
    expiry_nxt    = expiry_r;
    expire        = 1'b0;

    result = '0;

    case (req.op)
      dzcs_pkg::OP_TICK: begin
        tick_cnt_nxt = tick_cnt_r + 32'd1;
        if (running_r && countdown_r != 16'd0) begin
          countdown_nxt = countdown_r - 16'd1;
          if (countdown_r == 16'd1 && cfg.period_ms != 16'd0) begin
            expire = 1'b1;
            if (first_r[slot]) begin
              first_nxt[slot] = 1'b0;
            end else begin
              if (dt < min_r) begin
                min_nxt = dt;
              end
              if (dt > max_r) begin
                max_nxt = dt;
              end
            end
            expiry_nxt = tick_cnt_nxt;
            need_long_nxt[slot] = 1'b0;
            if (cfg.two_ranks && RANKS > 1) begin
              rank_ptr_nxt = ~rank_ptr_r;
            end
            countdown_nxt = reload;
            result.cal_issued       = 1'b1;
            result.cal_long         = need_long_r[slot];
            result.cal_rank         = rank_ptr_r;
            result.next_delay_ticks = reload;
          end
        end
      end
      dzcs_pkg::OP_START: begin
        running_nxt   = 1'b1;
        countdown_nxt = 16'd1;
        rank_ptr_nxt  = cfg.rank0_absent;
        first_nxt     = '1;
      end
      dzcs_pkg::OP_STOP: begin
        running_nxt   = 1'b0;
        countdown_nxt = 16'd0;
      end
      default: begin
      end
    endcase

    result.interval_min     = min_nxt;
    result.interval_max     = max_nxt;
    result.last_expiry_tick = expiry_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= 1'b0;
      countdown_r <= 16'd0;
      rank_ptr_r  <= 1'b0;
      need_long_r <= '1;
      first_r     <= '0;
      min_r       <= '1;
      max_r       <= '0;
      tick_cnt_r  <= '0;
      expiry_r    <= '0;
    end else if (req.fire) begin
      running_r   <= running_nxt;
      countdown_r <= countdown_nxt;
      rank_ptr_r  <= rank_ptr_nxt;
      need_long_r <= need_long_nxt;
      first_r     <= first_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      tick_cnt_r  <= tick_cnt_nxt;
      expiry_r    <= expiry_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.fire && expire) begin
      prev_stamp_r[slot] <= req.stamp;
    end
  end

endmodule

// ----- design/dram_zq_calibration_scheduler_core.sv -----
// ----------------------------------------------------------------------------
// DRAM ZQ calibration scheduler
// Schedules long and short ZQ calibrations over one or two ranks from tick,
// start and stop event words.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  takes event words: op (tick, start, stop) and a 32-bit cycle stamp.
//   out_ch gives exactly one result word per event word: issue flag, long or
//   short, rank, reload delay and the interval and expiry statistics.
//   cfg_we/cfg_index/cfg_wdata write period_ms (0), two_ranks (1) and
//   rank0_absent (2); write only while no event word is in flight.
// Path: an event word taken on in_ch loads the input register; when the
//   output register is free, the state update and the result register load
//   from it and the result word is shown on out_ch.
// Throughput: one event word per cycle unless out_ch stalls; the state loop
//   via countdown, rank rotation and reload multiplier is combinational.
// Reset: synchronous, active low; clears state, loads period_ms 100 and
//   marks every rank as needing a long calibration. No clearing pass.
// Stall: a held result word keeps its register; one more event word waits in
//   the input register, after which in_ch.ready drops until out_ch.ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dram_zq_calibration_scheduler_core #(
  parameter int unsigned MS_PER_TICK = 10,
  parameter int unsigned RANKS       = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  dzcs_in_if.sink      in_ch,
  dzcs_out_if.source   out_ch,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_wdata
);

  dzcs_pkg::cfg_t      cfg_r;
  logic                in_valid_r;
  logic [1:0]          in_op_r;
  logic [31:0]         in_stamp_r;
  logic                out_valid_r;
  dzcs_pkg::out_word_t out_word_r;

  logic                out_free;
  logic                advance;
  logic [15:0]         reload;
  dzcs_pkg::step_req_t req;
  dzcs_pkg::out_word_t result;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign advance     = in_valid_r && out_free;
  assign in_ch.ready = !in_valid_r || advance;

  assign req.fire  = advance;
  assign req.op    = dzcs_pkg::op_t'(in_op_r);
  assign req.stamp = in_stamp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.period_ms    <= dzcs_pkg::PERIOD_RESET;
      cfg_r.two_ranks    <= 1'b0;
      cfg_r.rank0_absent <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dzcs_pkg::CFG_PERIOD_MS:    cfg_r.period_ms    <= cfg_wdata;
        dzcs_pkg::CFG_TWO_RANKS:    cfg_r.two_ranks    <= cfg_wdata[0];
        dzcs_pkg::CFG_RANK0_ABSENT: cfg_r.rank0_absent <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  dzcs_reload #(
    .MS_PER_TICK (MS_PER_TICK)
  ) u_reload (
    .period_ms (cfg_r.period_ms),
    .two_ranks (cfg_r.two_ranks),
    .reload    (reload)
  );

  dzcs_sched #(
    .RANKS (RANKS)
  ) u_sched (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .reload (reload),
    .req    (req),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_op_r    <= in_ch.op;
      in_stamp_r <= in_ch.cycle_stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word_r <= result;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.cal_issued       = out_word_r.cal_issued;
  assign out_ch.cal_long         = out_word_r.cal_long;
  assign out_ch.cal_rank         = out_word_r.cal_rank;
  assign out_ch.next_delay_ticks = out_word_r.next_delay_ticks;
  assign out_ch.interval_min     = out_word_r.interval_min;
  assign out_ch.interval_max     = out_word_r.interval_max;
  assign out_ch.last_expiry_tick = out_word_r.last_expiry_tick;

`include "dram_zq_calibration_scheduler_core_assert.svh"

  `DZCS_ASSERT_NOW(a_issue_has_delay, out_valid_r && out_word_r.cal_issued,
    out_word_r.next_delay_ticks != 16'd0, "issued word with zero reload")
  `DZCS_ASSERT_NOW(a_idle_word_clear, out_valid_r && !out_word_r.cal_issued,
    !out_word_r.cal_long && !out_word_r.cal_rank && out_word_r.next_delay_ticks == 16'd0,
    "command fields set without issue")
  `DZCS_ASSERT_NOW(a_min_le_max, out_valid_r && out_word_r.interval_max != 32'd0,
    out_word_r.interval_min <= out_word_r.interval_max, "interval min above max")
  `DZCS_ASSERT_NEXT(a_in_hold, in_valid_r && !out_free,
    in_valid_r && $stable(in_stamp_r) && $stable(in_op_r), "pending word lost")

endmodule
